/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in %m");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed in %m");

`endif

/* hdl/ile_pkg.sv */
package ile_pkg;

    // Field widths fixed by the item layout
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Default list depth
    localparam int DEPTH_DEF = 16;

    // Operation codes
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_APPEND = 2'd0;
    localparam t_op OP_GET    = 2'd1;
    localparam t_op OP_REMOVE = 2'd2;

    // Status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_BADINDEX = 2'd2;

    // Per-cell control from the list controller
    typedef struct packed {
        logic wr_en;
        logic shift_en;
    } t_cell_ctl;

endpackage

/* hdl/ile_stream_if.sv */
// Request channel: one list operation per item
interface ile_req_if;
    logic                               valid;
    logic                               ready;
    logic [ile_pkg::OP_W-1:0]           op;
    logic signed [ile_pkg::DATA_W-1:0]  value;
    logic [ile_pkg::INDEX_W-1:0]        index;

    modport source (output valid, output op, output value, output index, input ready);
    modport sink   (input valid, input op, input value, input index, output ready);
endinterface

// Response channel: one result per request
interface ile_rsp_if #(
    parameter int COUNT_W = $clog2(ile_pkg::DEPTH_DEF + 1)
);
    logic                               valid;
    logic                               ready;
    logic signed [ile_pkg::DATA_W-1:0]  data;
    logic [COUNT_W-1:0]                 count;
    logic [ile_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output data, output count, output status, input ready);
    modport sink   (input valid, input data, input count, input status, output ready);
endinterface

/* hdl/ile_cell.sv */
// One list position: load on append, take the upper neighbor on remove.
module ile_cell (
    input  logic                        i_clk,
    input  ile_pkg::t_cell_ctl          i_ctl,
    input  logic [ile_pkg::DATA_W-1:0]  i_wr_data,
    input  logic [ile_pkg::DATA_W-1:0]  i_next_data,
    output logic [ile_pkg::DATA_W-1:0]  o_data
);

    logic [ile_pkg::DATA_W-1:0] r_data;

    // Hold unless loaded or shifted down
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_data <= i_wr_data;
        end else if (i_ctl.shift_en) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

/* hdl/indexed_list_engine.sv */
// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells.
// i_req carries one operation per item: append (value), get (index) or
// remove (index). o_rsp returns exactly one item per request: the entry read,
// removed or appended, the entry count after the operation, and a status
// (ok, list full, index not below count). Refused operations leave the list
// unchanged and return data 0; the unused op code returns status ok, data 0.
// A request accepted at one edge is registered and shows on o_rsp after that
// edge. Throughput is one item per cycle while the receiver keeps up: every
// cell updates in the same cycle, a remove shifting each later entry down one
// cell at once, and the read comes from a one-of-sixteen select over the
// front cells. The response register frees as it is taken, so a new request
// is accepted while the held result is consumed; when the receiver stalls,
// the result holds and i_req.ready stays low until it is taken.
// Reset (synchronous, active low) empties the list and drops any pending
// result; cell contents are not cleared, since only entries below the count
// are ever read.
module indexed_list_engine #(
    parameter int DEPTH   = ile_pkg::DEPTH_DEF,
    parameter int COUNT_W = $clog2(DEPTH + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ile_req_if.sink     i_req,
    ile_rsp_if.source   o_rsp
);

    localparam int CMP_W = (COUNT_W > ile_pkg::INDEX_W) ? COUNT_W : ile_pkg::INDEX_W;
    localparam int N_SEL = (DEPTH < (2 ** ile_pkg::INDEX_W)) ? DEPTH
                                                            : (2 ** ile_pkg::INDEX_W);

    logic [COUNT_W-1:0]            r_count;
    logic [COUNT_W-1:0]            n_count;
    logic                          r_rsp_valid;
    logic [ile_pkg::DATA_W-1:0]    r_rsp_data;
    logic [ile_pkg::DATA_W-1:0]    n_rsp_data;
    logic [COUNT_W-1:0]            r_rsp_count;
    ile_pkg::t_status              r_rsp_status;
    ile_pkg::t_status              n_rsp_status;

    logic                          w_accept;
    logic                          w_do_append;
    logic                          w_do_remove;
    logic                          w_full;
    logic                          w_in_range;
    logic [CMP_W-1:0]              w_cnt_x;
    logic [CMP_W-1:0]              w_idx_x;
    logic [ile_pkg::DATA_W-1:0]    w_rd_data;
    logic [ile_pkg::DATA_W-1:0]    w_cell_data [DEPTH];

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_cnt_x    = CMP_W'(r_count);
    assign w_idx_x    = CMP_W'(i_req.index);
    assign w_full     = (r_count == COUNT_W'(DEPTH));
    assign w_in_range = (w_idx_x < w_cnt_x);

    // Select the entry at the requested index from the front cells
    always_comb begin
        w_rd_data = '0;
        for (int k = 0; k < N_SEL; k++) begin
            if (i_req.index == ile_pkg::INDEX_W'(k)) begin
                w_rd_data = w_rd_data | w_cell_data[k];
            end
        end
    end

    // Decode the operation
    always_comb begin
        w_do_append  = 1'b0;
        w_do_remove  = 1'b0;
        n_count      = r_count;
        n_rsp_data   = '0;
        n_rsp_status = ile_pkg::ST_OK;
        case (i_req.op)
            ile_pkg::OP_APPEND: begin
                if (w_full) begin
                    n_rsp_status = ile_pkg::ST_FULL;
                end else begin
                    w_do_append = w_accept;
                    n_count     = r_count + COUNT_W'(1);
                    n_rsp_data  = i_req.value;
                end
            end
            ile_pkg::OP_GET: begin
                if (!w_in_range) begin
                    n_rsp_status = ile_pkg::ST_BADINDEX;
                end else begin
                    n_rsp_data = w_rd_data;
                end
            end
            ile_pkg::OP_REMOVE: begin
                if (!w_in_range) begin
                    n_rsp_status = ile_pkg::ST_BADINDEX;
                end else begin
                    w_do_remove = w_accept;
                    n_count     = r_count - COUNT_W'(1);
                    n_rsp_data  = w_rd_data;
                end
            end
            default: begin
                n_rsp_status = ile_pkg::ST_OK;
            end
        endcase
    end

    // Row of cells, each fed by its upper neighbor
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam logic [CMP_W-1:0] K_POS  = CMP_W'(k);
        localparam logic [CMP_W-1:0] K_NEXT = CMP_W'(k + 1);
        ile_pkg::t_cell_ctl         w_ctl;
        logic [ile_pkg::DATA_W-1:0] w_next;

        assign w_ctl.wr_en    = w_do_append && (w_cnt_x == K_POS);
        assign w_ctl.shift_en = w_do_remove && (K_POS >= w_idx_x) && (K_NEXT < w_cnt_x);

        if (k == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_data[k + 1];
        end

        ile_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_wr_data   (i_req.value),
            .i_next_data (w_next),
            .o_data      (w_cell_data[k])
        );
    end

    // Track the entry count and the response valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Capture the response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp_data   <= n_rsp_data;
            r_rsp_count  <= n_count;
            r_rsp_status <= n_rsp_status;
        end
    end

    assign o_rsp.valid  = r_rsp_valid;
    assign o_rsp.data   = r_rsp_data;
    assign o_rsp.count  = r_rsp_count;
    assign o_rsp.status = r_rsp_status;

endmodule

/* hdl/ile_checker.sv */
`include "assert_macros.svh"

// Port-level checks for the list engine
module ile_checker #(
    parameter int DEPTH   = ile_pkg::DEPTH_DEF,
    parameter int COUNT_W = $clog2(DEPTH + 1)
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [ile_pkg::DATA_W-1:0]   i_rsp_data,
    input logic [COUNT_W-1:0]           i_rsp_count,
    input logic [ile_pkg::STATUS_W-1:0] i_rsp_status
);

    // No result survives reset
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_rsp_valid)

    // Every accepted request produces a result on the next cycle
    `ASSERT_CLK(a_accept_gives_rsp, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> i_rsp_valid)

    // A full refusal reports a full list and no data
    `ASSERT_CLK(a_full_shape, i_clk, i_rst_n, (i_rsp_valid && i_rsp_status == ile_pkg::ST_FULL) |-> (i_rsp_count == COUNT_W'(DEPTH) && i_rsp_data == '0))

    // A stalled result holds its payload
    `ASSERT_CLK(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data) && $stable(i_rsp_count) && $stable(i_rsp_status)))

endmodule

bind indexed_list_engine ile_checker #(
    .DEPTH   (DEPTH),
    .COUNT_W (COUNT_W)
) u_ile_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_data   (o_rsp.data),
    .i_rsp_count  (o_rsp.count),
    .i_rsp_status (o_rsp.status)
);

/* tb/indexed_list_engine_test.sv */
module indexed_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DEPTH        = ile_pkg::DEPTH_DEF;
    localparam int  COUNT_W      = $clog2(DEPTH + 1);
    localparam int  POS_W        = $clog2(DEPTH);
    localparam int  RANDOM_ITEMS = 1700;
    localparam int  IDLE_LIMIT   = 2000;
    localparam int  MAX_SHOWN    = 10;
    localparam ile_pkg::t_op OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [ile_pkg::DATA_W-1:0] data;
        logic [COUNT_W-1:0]                count;
        ile_pkg::t_status                  status;
    } t_list_rsp;

    // One line of the directed sequence; rsp is used only when typed is set
    typedef struct {
        ile_pkg::t_op                 op;
        logic [ile_pkg::DATA_W-1:0]   value;
        logic [ile_pkg::INDEX_W-1:0]  index;
        int                           reps;
        bit                           typed;
        t_list_rsp                    rsp;
    } t_dir_row;

    typedef struct {
        bit        typed;
        t_list_rsp rsp;
    } t_typed_rsp;

    logic i_clk;
    logic i_rst_n;

    ile_req_if req_if ();
    ile_rsp_if rsp_if ();

    indexed_list_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Mirror of the list contents and length
    logic signed [ile_pkg::DATA_W-1:0] list_mem [DEPTH];
    logic [COUNT_W-1:0]                list_len;

    t_list_rsp  list_rsp_q [$];
    t_typed_rsp typed_rsp_q [$];
    t_dir_row   dir_rows [$];

    int err_count;
    int n_results;
    int n_append, n_get, n_remove, n_unused;
    int n_full, n_badidx, n_hit_full, n_emptied;
    int idle_cycles;
    int burst_left;

    // Receiver stall pattern state
    int unsigned rx_mode, rx_mode_left, rx_hold_left;
    logic [31:0] rx_pat;
    logic        rx_level;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the list mirror and return the response it owes
    function automatic t_list_rsp apply_list_op(ile_pkg::t_op op,
                                                logic signed [ile_pkg::DATA_W-1:0] value,
                                                logic [ile_pkg::INDEX_W-1:0] index);
        t_list_rsp r;
        r.data   = '0;
        r.status = ile_pkg::ST_OK;
        case (op)
            ile_pkg::OP_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ile_pkg::ST_FULL;
                end else begin
                    list_mem[list_len[POS_W-1:0]] = value;
                    list_len++;
                    r.data = value;
                end
            end
            ile_pkg::OP_GET, ile_pkg::OP_REMOVE: begin
                if (index >= list_len) begin
                    r.status = ile_pkg::ST_BADINDEX;
                end else begin
                    r.data = list_mem[index];
                    if (op == ile_pkg::OP_REMOVE) begin
                        // close the gap: later entries move down one place
                        for (int i = index; i + 1 < list_len; i++)
                            list_mem[POS_W'(i)] = list_mem[POS_W'(i + 1)];
                        list_len--;
                    end
                end
            end
            default: ;
        endcase
        r.count = list_len;
        return r;
    endfunction

    function automatic void flag_field(string field, longint want, longint got);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                     $realtime, field, n_results, want, got);
    endfunction

    task automatic add_row(ile_pkg::t_op op, logic [ile_pkg::DATA_W-1:0] value,
                           logic [ile_pkg::INDEX_W-1:0] index,
                           int reps, bit typed, logic [ile_pkg::DATA_W-1:0] exp_data,
                           logic [COUNT_W-1:0] exp_count, ile_pkg::t_status exp_status);
        t_dir_row r;
        r.op         = op;
        r.value      = value;
        r.index      = index;
        r.reps       = reps;
        r.typed      = typed;
        r.rsp.data   = exp_data;
        r.rsp.count  = exp_count;
        r.rsp.status = exp_status;
        dir_rows.push_back(r);
    endtask

    // Present one item (caller is at a falling edge) and hold it until taken
    task automatic send_op(ile_pkg::t_op op, logic [ile_pkg::DATA_W-1:0] value,
                           logic [ile_pkg::INDEX_W-1:0] index,
                           bit typed, t_list_rsp rsp);
        t_typed_rsp t;
        t.typed = typed;
        t.rsp   = rsp;
        typed_rsp_q.push_back(t);
        req_if.valid = 1'b1;
        req_if.op    = op;
        req_if.value = value;
        req_if.index = index;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Burst pacing: after a burst, drop valid for a random gap
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 20);
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
    endtask

    // Receiver ready on a pattern that changes mode every so often
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
                rx_pat       = $urandom | 32'h1;
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: rsp_if.ready = 1'b1;
                1: rsp_if.ready = ($urandom_range(0, 3) != 0);
                2: begin
                    rsp_if.ready = rx_pat[0];
                    rx_pat = {rx_pat[0], rx_pat[31:1]};
                end
                default: begin
                    if (rx_hold_left == 0) begin
                        rx_hold_left = $urandom_range(1, 30);
                        rx_level     = ~rx_level;
                    end
                    rx_hold_left--;
                    rsp_if.ready = rx_level;
                end
            endcase
        end
    end

    // Check results in order and record each accepted operation
    always @(posedge i_clk) begin
        t_list_rsp  got, want, pred;
        t_typed_rsp t;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.data   = rsp_if.data;
                got.count  = rsp_if.count;
                got.status = rsp_if.status;
                n_results++;
                if (list_rsp_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("%0t: result %0d arrived with nothing owed: data %0d",
                                 $realtime, n_results, $signed(got.data));
                end else begin
                    want = list_rsp_q.pop_front();
                    if (got.data !== want.data)
                        flag_field("data", longint'($signed(want.data)),
                                   longint'($signed(got.data)));
                    if (got.count !== want.count)
                        flag_field("count", longint'(want.count), longint'(got.count));
                    if (got.status !== want.status)
                        flag_field("status", longint'(want.status), longint'(got.status));
                end
            end
            if (req_if.valid && req_if.ready) begin
                pred = apply_list_op(req_if.op, req_if.value, req_if.index);
                t    = typed_rsp_q.pop_front();
                list_rsp_q.push_back(t.typed ? t.rsp : pred);
                case (req_if.op)
                    ile_pkg::OP_APPEND: n_append++;
                    ile_pkg::OP_GET:    n_get++;
                    ile_pkg::OP_REMOVE: n_remove++;
                    default:            n_unused++;
                endcase
                if (pred.status == ile_pkg::ST_FULL)     n_full++;
                if (pred.status == ile_pkg::ST_BADINDEX) n_badidx++;
                if (req_if.op == ile_pkg::OP_APPEND && pred.status == ile_pkg::ST_OK
                        && list_len == DEPTH)
                    n_hit_full++;
                if (req_if.op == ile_pkg::OP_REMOVE && pred.status == ile_pkg::ST_OK
                        && list_len == 0)
                    n_emptied++;
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row                    row;
        t_list_rsp                   no_rsp;
        ile_pkg::t_op                op;
        logic [ile_pkg::DATA_W-1:0]  value;
        logic [ile_pkg::INDEX_W-1:0] index;
        int                          append_pct;
        int                          sent;
        int                          pick;

        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.op    = ile_pkg::OP_APPEND;
        req_if.value = '0;
        req_if.index = '0;
        rsp_if.ready = 1'b0;
        list_len     = '0;
        no_rsp       = '0;
        err_count    = 0;
        n_results    = 0;
        idle_cycles  = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
        rx_hold_left = 0;
        rx_pat       = 32'h1;
        rx_level     = 1'b0;
        burst_left   = $urandom_range(1, 40);
        {n_append, n_get, n_remove, n_unused} = '0;
        {n_full, n_badidx, n_hit_full, n_emptied} = '0;

        // Directed sequence: empty list, extremes, fill to full, drain
        add_row(ile_pkg::OP_GET,    32'h0,        4'd0,  1, 1, 32'h0,        5'd0,
                ile_pkg::ST_BADINDEX);
        add_row(ile_pkg::OP_REMOVE, 32'h0,        4'd15, 1, 1, 32'h0,        5'd0,
                ile_pkg::ST_BADINDEX);
        add_row(OP_UNUSED,          32'hFFFFFFFF, 4'd15, 1, 1, 32'h0,        5'd0,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_APPEND, 32'h7FFFFFFF, 4'd15, 1, 1, 32'h7FFFFFFF, 5'd1,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_APPEND, 32'h80000000, 4'd0,  1, 1, 32'h80000000, 5'd2,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_APPEND, 32'h0,        4'd0,  1, 1, 32'h0,        5'd3,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_APPEND, 32'hFFFFFFFF, 4'd0,  1, 1, 32'hFFFFFFFF, 5'd4,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_GET,    32'h0,        4'd1,  1, 1, 32'h80000000, 5'd4,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_GET,    32'h0,        4'd4,  1, 1, 32'h0,        5'd4,
                ile_pkg::ST_BADINDEX);
        add_row(ile_pkg::OP_REMOVE, 32'h0,        4'd0,  1, 1, 32'h7FFFFFFF, 5'd3,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_GET,    32'hFFFFFFFF, 4'd0,  1, 0, 32'h0,        5'd0,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_APPEND, 32'h12340000, 4'd0, 13, 0, 32'h0,        5'd0,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_APPEND, 32'h55555555, 4'd0,  1, 1, 32'h0,        5'd16,
                ile_pkg::ST_FULL);
        add_row(ile_pkg::OP_GET,    32'h0,        4'd15, 1, 0, 32'h0,        5'd0,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_REMOVE, 32'h0,        4'd15, 1, 0, 32'h0,        5'd0,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_APPEND, 32'hAAAAAAAA, 4'd0,  1, 1, 32'hAAAAAAAA, 5'd16,
                ile_pkg::ST_OK);
        add_row(OP_UNUSED,          32'h5A5A5A5A, 4'd3,  1, 1, 32'h0,        5'd16,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_REMOVE, 32'h0,        4'd7,  1, 0, 32'h0,        5'd0,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_GET,    32'h0,        4'd7,  1, 0, 32'h0,        5'd0,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_GET,    32'h0,        4'd15, 1, 1, 32'h0,        5'd15,
                ile_pkg::ST_BADINDEX);
        add_row(ile_pkg::OP_REMOVE, 32'h0,        4'd0, 15, 0, 32'h0,        5'd0,
                ile_pkg::ST_OK);
        add_row(ile_pkg::OP_REMOVE, 32'h0,        4'd0,  1, 1, 32'h0,        5'd0,
                ile_pkg::ST_BADINDEX);

        // Hold reset, then release at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            for (int k = 0; k < row.reps; k++) begin
                @(negedge i_clk);
                send_op(row.op, row.value + k, row.index, row.typed, row.rsp);
                pace_sender();
            end
        end

        // Random operations in phases that lean toward filling or draining
        sent       = 0;
        append_pct = 50;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 150 == 0) begin
                pick = $urandom_range(0, 2);
                append_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
            end
            @(negedge i_clk);
            pick = $urandom_range(0, 7);
            case (pick)
                0:       value = 32'h7FFFFFFF;
                1:       value = 32'h80000000;
                2:       value = $urandom_range(0, 31) - 16;
                default: value = $urandom;
            endcase
            index = ile_pkg::INDEX_W'($urandom);
            if ($urandom_range(0, 99) < 3) begin
                op = OP_UNUSED;
            end else begin
                if ($urandom_range(0, 99) < append_pct)
                    op = ile_pkg::OP_APPEND;
                else
                    op = $urandom_range(0, 1) ? ile_pkg::OP_GET : ile_pkg::OP_REMOVE;
                // keep most indexes in range so the list stays busy
                if (op != ile_pkg::OP_APPEND && list_len != 0 && $urandom_range(0, 99) < 88)
                    index = ile_pkg::INDEX_W'($urandom_range(0, list_len - 1));
                sent++;
            end
            send_op(op, value, index, 1'b0, no_rsp);
            pace_sender();
        end

        @(negedge i_clk);
        req_if.valid = 1'b0;

        // Drain outstanding results, then idle before the summary
        while (list_rsp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d appends, %0d gets, %0d removes and %0d unused ops; %0d results",
                 n_append, n_get, n_remove, n_unused, n_results);
        $display("Refused %0d full, %0d bad index; list filled %0d times, emptied %0d; %0d errors",
                 n_full, n_badidx, n_hit_full, n_emptied, err_count);
        if (err_count == 0 && list_rsp_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/ile_pkg.sv
hdl/ile_stream_if.sv
hdl/ile_cell.sv
hdl/indexed_list_engine.sv
hdl/ile_checker.sv
tb/indexed_list_engine_test.sv
